FILE: hw/rtl/fir_decimate_by_two_framer_assert.svh
// assertion macros shared by the decimating filter rtl
`ifndef FIR_DECIMATE_BY_TWO_FRAMER_ASSERT_SVH
`define FIR_DECIMATE_BY_TWO_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent holds, consequent holds in the same cycle
`define FDBF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdbf assertion failed");

// antecedent holds, consequent holds in the next cycle
`define FDBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdbf assertion failed");

`else

`define FDBF_ASSERT_SAME(label, clk, rst, ante, cons)
`define FDBF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/fdbf_pkg.sv
// types, constants and coefficient table of the decimating filter
`timescale 1ns / 1ps

package fdbf_pkg;

   localparam int TAP_COUNT          = 31;
   localparam int TAP_IDX_W          = $clog2(TAP_COUNT);
   localparam int TABLE_FRAC_BITS    = 24;
   localparam int SAMPLE_W           = 16;
   localparam int FRAME_W            = 8;
   localparam logic [FRAME_W-1:0] FRAME_LENGTH_RESET = 8'd80;

   // hamming windowed sinc, cutoff 0.25, unity dc gain, q1.24
   localparam logic signed [31:0] TAP_Q24 [TAP_COUNT] = '{
      -32'sd28528,    32'sd0,  32'sd49280,   32'sd0, -32'sd112914,  32'sd0,
       32'sd236455,   32'sd0, -32'sd449378,  32'sd0,  32'sd823745,  32'sd0,
      -32'sd1626356,  32'sd0,  32'sd5295220, 32'sd8402171,
       32'sd5295220,  32'sd0, -32'sd1626356, 32'sd0,  32'sd823745,  32'sd0,
      -32'sd449378,   32'sd0,  32'sd236455,  32'sd0, -32'sd112914,  32'sd0,
       32'sd49280,    32'sd0, -32'sd28528
   };

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctrl_type;

   // tap brought to frac_bits fraction bits, round half away from zero
   function automatic logic signed [31:0] tap_coef(input logic [TAP_IDX_W-1:0] idx,
                                                  input int frac_bits);
      logic signed [31:0] raw;
      logic [31:0]        mag;
      logic               neg;
      int                 sh;
      raw = TAP_Q24[idx];
      sh  = TABLE_FRAC_BITS - frac_bits;
      if (sh <= 0) begin
         return raw;
      end
      neg = raw[31];
      mag = neg ? 32'(-raw) : 32'(raw);
      mag = (mag + (32'd1 << (sh - 1))) >> sh;
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

FILE: hw/rtl/fdbf_req_if.sv
// input channel: one high rate sample per beat
`timescale 1ns / 1ps

interface fdbf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fdbf_pkg::SAMPLE_W-1:0]  sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

FILE: hw/rtl/fdbf_rsp_if.sv
// result channel: one decimated sample and frame flag per beat
`timescale 1ns / 1ps

interface fdbf_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fdbf_pkg::SAMPLE_W-1:0]  sample_out;
   logic                                  frame_end;

   modport source (output valid, output sample_out, output frame_end, input ready);
   modport sink (input valid, input sample_out, input frame_end, output ready);
endinterface

FILE: hw/rtl/fir_decimate_by_two_framer.sv
// 31-tap low-pass decimate-by-two filter with output framing
//
// req_chan carries one signed 16-bit sample per beat. Every sample is shifted
// into the history; every second one (the second after reset, then every
// other) starts a filter pass that gives one beat on rsp_chan: the rounded,
// saturated filter output and frame_end, set on the last output of a frame.
// csr_we / csr_wdata write the frame length (0 means 256); write it only
// while the block is idle.
// Timing: a sample that does not complete a pair is taken without a pass
// and req_chan.ready stays high. A pair-completing sample runs the shared
// multiplier over the 31 taps, one tap a cycle, then a drain state and a
// rounding state. Ready is low while the pass runs, and the result is
// registered on rsp_chan as the pass leaves its rounding state.
// While a result waits on rsp_chan the next non-emitting sample is still
// taken; a finished pass holds in its rounding state until the result
// register frees. Reset clears the history, phase, frame count and output
// valid, and sets the frame length to 80.
`timescale 1ns / 1ps
`include "fir_decimate_by_two_framer_assert.svh"

module fir_decimate_by_two_framer #(
   parameter int COEF_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   fdbf_req_if.sink                      req_chan,
   fdbf_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [fdbf_pkg::FRAME_W-1:0]  csr_wdata
);

   localparam int SW     = fdbf_pkg::SAMPLE_W;
   localparam int TAPS   = fdbf_pkg::TAP_COUNT;
   localparam int IW     = fdbf_pkg::TAP_IDX_W;
   localparam int FW     = fdbf_pkg::FRAME_W;
   localparam int COEF_W = COEF_FRAC_BITS + 2;
   localparam int ACC_W  = SW + COEF_W + IW;
   localparam logic [IW-1:0] TAP_LAST = IW'(TAPS - 1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [IW-1:0]           tap_ff, tap_in;
   logic                    phase_ff, phase_in;
   logic [FW-1:0]           frame_count_ff, frame_count_in;
   logic [FW-1:0]           frame_length_ff, frame_length_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                    rsp_end_ff, rsp_end_in;
   logic signed [SW-1:0]    history_ff [TAPS];

   logic                    req_beat;
   logic                    out_write;
   fdbf_pkg::mac_ctrl_type  mac_ctrl;
   logic signed [COEF_W-1:0] coef;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [ACC_W-1:0] acc_shift;
   logic signed [SW-1:0]    sat_value;
   logic [FW:0]             frame_len_eff;
   logic [FW:0]             frame_next;
   logic                    frame_last;

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign req_beat        = req_chan.valid && req_chan.ready;
   assign out_write       = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // sample history, newest at entry zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            history_ff[i] <= '0;
         end
      end else if (req_beat) begin
         history_ff[0] <= req_chan.sample_in;
         for (int i = 1; i < TAPS; i++) begin
            history_ff[i] <= history_ff[i-1];
         end
      end
   end

   // coefficient for the current tap from the constant table
   assign coef = COEF_W'(fdbf_pkg::tap_coef(tap_ff, COEF_FRAC_BITS));

   // shared multiply-accumulate control
   always_comb begin
      mac_ctrl.clear  = req_beat && phase_ff;
      mac_ctrl.mul_en = (state_ff == ST_MAC);
      mac_ctrl.acc_en = ((state_ff == ST_MAC) && (tap_ff != '0)) || (state_ff == ST_DRAIN);
   end

   fdbf_mac #(
      .COEF_W (COEF_W),
      .ACC_W  (ACC_W)
   ) u_mac (
      .clock     (clock),
      .ctrl      (mac_ctrl),
      .sample_in (history_ff[tap_ff]),
      .coef_in   (coef),
      .acc_out   (acc)
   );

   // round half away from zero, then saturate
   always_comb begin
      acc_rnd   = acc + ROUND_HALF - ACC_W'(acc[ACC_W-1]);
      acc_shift = acc_rnd >>> COEF_FRAC_BITS;
      if (acc_shift > SAT_MAX) begin
         sat_value = 16'sh7fff;
      end else if (acc_shift < SAT_MIN) begin
         sat_value = 16'sh8000;
      end else begin
         sat_value = SW'(acc_shift);
      end
   end

   // frame position, zero length means a frame of 256
   always_comb begin
      frame_len_eff = (frame_length_ff == '0) ? (FW+1)'(1 << FW) : {1'b0, frame_length_ff};
      frame_next    = {1'b0, frame_count_ff} + (FW+1)'(1);
      frame_last    = (frame_next >= frame_len_eff);
   end

   // sequencer next state
   always_comb begin
      state_in        = state_ff;
      tap_in          = tap_ff;
      phase_in        = phase_ff;
      frame_count_in  = frame_count_ff;
      frame_length_in = frame_length_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_end_in      = rsp_end_ff;

      if (csr_we) begin
         frame_length_in = csr_wdata;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               phase_in = ~phase_ff;
               if (phase_ff) begin
                  state_in = ST_MAC;
                  tap_in   = '0;
               end
            end
         end
         ST_MAC: begin
            if (tap_ff == TAP_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_write) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = sat_value;
               rsp_end_in     = frame_last;
               frame_count_in = frame_last ? '0 : frame_next[FW-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         tap_ff          <= '0;
         phase_ff        <= 1'b0;
         frame_count_ff  <= '0;
         frame_length_ff <= fdbf_pkg::FRAME_LENGTH_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         tap_ff          <= tap_in;
         phase_ff        <= phase_in;
         frame_count_ff  <= frame_count_in;
         frame_length_ff <= frame_length_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;
   assign rsp_chan.frame_end  = rsp_end_ff;

   // checks on the sequencer
   `FDBF_ASSERT_NEXT(a_pair_starts_pass, clock, reset, req_beat && phase_ff,
                     state_ff == ST_MAC && tap_ff == '0)
   `FDBF_ASSERT_NEXT(a_odd_stays_idle, clock, reset, req_beat && !phase_ff,
                     state_ff == ST_IDLE)
   `FDBF_ASSERT_SAME(a_tap_in_range, clock, reset, state_ff == ST_MAC,
                     tap_ff <= TAP_LAST)
   `FDBF_ASSERT_NEXT(a_frame_wraps, clock, reset, out_write && frame_last,
                     frame_count_ff == '0 && rsp_end_ff)

endmodule

FILE: hw/rtl/fdbf_mac.sv
// shared multiply-accumulate unit, one tap per cycle
`timescale 1ns / 1ps

module fdbf_mac #(
   parameter int COEF_W = 17,
   parameter int ACC_W  = 38
) (
   input  logic                                 clock,
   input  fdbf_pkg::mac_ctrl_type               ctrl,
   input  logic signed [fdbf_pkg::SAMPLE_W-1:0] sample_in,
   input  logic signed [COEF_W-1:0]             coef_in,
   output logic signed [ACC_W-1:0]              acc_out
);

   localparam int PROD_W = fdbf_pkg::SAMPLE_W + COEF_W;

   logic signed [PROD_W-1:0] product_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // multiply stage then accumulate stage
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         product_ff <= PROD_W'(sample_in) * PROD_W'(coef_in);
      end
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.acc_en) begin
         acc_ff <= acc_ff + ACC_W'(product_ff);
      end
   end

   assign acc_out = acc_ff;

endmodule
